// ===== hdl/rq_pkg.sv =====
// Package for the randomized queue: widths, codes, controller command/status structs
// and the LFSR step function. No dependencies.
package rq_pkg;

	localparam int DEPTH_DEF   = 256;
	localparam int DATA_W_DEF  = 32;

	localparam int ITEM_W      = 32;
	localparam int ST_W        = 2;
	localparam int CNT_OUT_W   = 9;
	localparam int CAP_OUT_W   = 10;
	localparam int START_CAP_W = 9;
	localparam int OUT_FIELD_W = ST_W + ITEM_W + CNT_OUT_W + CAP_OUT_W;
	localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
	localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;
	localparam int IN_TDATA_W  = ITEM_W;

	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 32;
	localparam logic [CFG_IDX_W-1:0] CFG_FIXED     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_CAP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SEED      = 2'd2;

	localparam logic [ST_W-1:0] ST_OK      = 2'd0;
	localparam logic [ST_W-1:0] ST_RESIZED = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL    = 2'd2;
	localparam logic [ST_W-1:0] ST_EMPTY   = 2'd3;

	localparam logic OP_ENQ = 1'b0;
	localparam logic OP_DEQ = 1'b1;

	localparam int LFSR_W = 32;
	localparam logic [LFSR_W-1:0] LFSR_TOGGLE = 32'h8020_0003;

	// remainder unit: bits retired per cycle
	localparam int DIV_STEP   = 4;
	localparam int DIV_CYCLES = LFSR_W / DIV_STEP;
	localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

	typedef struct packed {
		logic take;
		logic refuse;
		logic dq_start;
		logic grow;
		logic enq_write;
		logic latch_last;
		logic rd_slot;
		logic move;
		logic shrink;
		logic load_out;
	} rq_cmd_t;

	typedef struct packed {
		logic is_deq;
		logic enq_refuse;
		logic cnt_zero;
		logic need_grow;
		logic need_shrink;
		logic div_busy;
		logic out_free;
	} rq_stat_t;

	function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] cur);
		logic [LFSR_W-1:0] nx;
		nx = {1'b0, cur[LFSR_W-1:1]};
		if (cur[0])
			nx = nx ^ LFSR_TOGGLE;
		return nx;
	endfunction

endpackage

// ===== hdl/randomized_queue_top.sv =====
// Randomized queue top level: stream ports, config port, controller and
// datapath. Depends on rq_pkg, rq_ctrl, rq_datapath.
//
//   port group   dir   beat contents
//   s_axis_*     in    tuser: mode; tdata: item_value
//   m_axis_*     out   tdata: status, item_out, entry_count, capacity_now
//   cfg_*        in    write enable, register index, data
//
// Enqueue: capacity doubles until above the count, then the write; refused beats skip both.
// Dequeue: the mod-count unit retires 4 LFSR bits a cycle, then slot read, move, write-back,
// then capacity halvings (a single one, to 1, if the last entry empties the queue).
// One item in flight; the next is taken once the result sits in the output register.
// Reset: count 0, capacity 1, LFSR 1, growing mode; entry memory not cleared.
// A stalled output holds its beat; the next item still enters and waits only at its end.
module randomized_queue_top #(
	parameter int DEPTH      = rq_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = rq_pkg::DATA_W_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [rq_pkg::IN_TDATA_W-1:0]   s_axis_tdata,   // [31:0] item_value
	input  logic                            s_axis_tuser,   // [0] mode
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [rq_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,   // [1:0] status, [33:2] item_out,
	                                                        // [42:34] entry_count,
	                                                        // [52:43] capacity_now, rest zero
	input  logic                            cfg_we,
	input  logic [rq_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rq_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import rq_pkg::*;

	rq_cmd_t  cmd;
	rq_stat_t stat;

	rq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	rq_datapath #(
		.DEPTH     (DEPTH),
		.DATA_WIDTH(DATA_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_mode  (s_axis_tuser),
		.in_value (s_axis_tdata),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_data (m_axis_tdata),
		.cmd      (cmd),
		.stat     (stat)
	);

endmodule

// ===== hdl/rq_mod_unit.sv =====
// Iterative remainder unit: dividend mod divisor, DIV_STEP bits a cycle.
// Depends on rq_pkg.
module rq_mod_unit #(
	parameter int CW = 9
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [rq_pkg::LFSR_W-1:0]  dividend,
	input  logic [CW-1:0]              divisor,
	output logic                       busy,
	output logic [CW-1:0]              rem
);
	import rq_pkg::*;

	logic                 run_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [LFSR_W-1:0]    sh_q;
	logic [CW-1:0]        rem_q;
	logic [CW-1:0]        rem_d;

	always_comb begin
		logic [CW:0]   t;
		logic [CW-1:0] r;
		r = rem_q;
		for (int i = 0; i < DIV_STEP; i++) begin
			t = {r, sh_q[LFSR_W-1-i]};
			if (t >= {1'b0, divisor})
				t = t - {1'b0, divisor};
			r = t[CW-1:0];
		end
		rem_d = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			cnt_q <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DIV_CNT_W'(DIV_CYCLES - 1))
				run_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= dividend;
			rem_q <= '0;
		end else if (run_q) begin
			sh_q  <= sh_q << DIV_STEP;
			rem_q <= rem_d;
		end
	end

	assign busy = run_q;
	assign rem  = rem_q;

endmodule

// ===== hdl/rq_ctrl.sv =====
// Controller state machine for the randomized queue.
// Depends on rq_pkg; drives rq_datapath through rq_cmd_t.
module rq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  rq_pkg::rq_stat_t stat,
	output rq_pkg::rq_cmd_t  cmd
);
	import rq_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_EVAL   = 4'd1;
	localparam logic [3:0] S_GROW   = 4'd2;
	localparam logic [3:0] S_DIV1   = 4'd3;
	localparam logic [3:0] S_DIV    = 4'd4;
	localparam logic [3:0] S_MOVE   = 4'd5;
	localparam logic [3:0] S_SHRINK = 4'd6;
	localparam logic [3:0] S_DONE   = 4'd7;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = S_EVAL;
				end
			end
			S_EVAL: begin
				if (stat.is_deq) begin
					if (stat.cnt_zero) begin
						cmd.refuse = 1'b1;
						state_d    = S_DONE;
					end else begin
						cmd.dq_start = 1'b1;
						state_d      = S_DIV1;
					end
				end else if (stat.enq_refuse) begin
					cmd.refuse = 1'b1;
					state_d    = S_DONE;
				end else begin
					state_d = S_GROW;
				end
			end
			S_GROW: begin
				if (stat.need_grow) begin
					cmd.grow = 1'b1;
				end else begin
					cmd.enq_write = 1'b1;
					state_d       = S_DONE;
				end
			end
			S_DIV1: begin
				cmd.latch_last = 1'b1;
				state_d        = S_DIV;
			end
			S_DIV: begin
				if (!stat.div_busy) begin
					cmd.rd_slot = 1'b1;
					state_d     = S_MOVE;
				end
			end
			S_MOVE: begin
				cmd.move = 1'b1;
				state_d  = S_SHRINK;
			end
			S_SHRINK: begin
				if (stat.need_shrink) begin
					cmd.shrink = 1'b1;
					if (stat.cnt_zero)
						state_d = S_DONE;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	assign in_ready = (state_q == S_IDLE);

endmodule

// ===== hdl/rq_datapath.sv =====
// Datapath: entry memory, count/capacity/LFSR state, remainder unit,
// output register. Depends on rq_pkg and rq_mod_unit.
module rq_datapath #(
	parameter int DEPTH      = rq_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = rq_pkg::DATA_W_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [rq_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rq_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                            in_mode,
	input  logic [rq_pkg::ITEM_W-1:0]       in_value,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [rq_pkg::OUT_TDATA_W-1:0]  out_data,
	input  rq_pkg::rq_cmd_t                 cmd,
	output rq_pkg::rq_stat_t                stat
);
	import rq_pkg::*;

	localparam int CW   = $clog2(DEPTH + 1);
	localparam int AW   = $clog2(DEPTH);
	localparam int CAPW = (CW + 1 > CAP_OUT_W) ? CW + 1 : CAP_OUT_W;
	localparam int XW   = CAPW + 2;

	logic [DATA_WIDTH-1:0] mem [DEPTH];

	logic [CW-1:0]          count_q;
	logic [CAPW-1:0]        cap_q;
	logic                   fixed_q;
	logic [LFSR_W-1:0]      lfsr_q;
	logic [LFSR_W-1:0]      lfsr_nx;
	logic                   out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;

	logic                   op_q;
	logic [DATA_WIDTH-1:0]  val_q;
	logic [ST_W-1:0]        res_st_q;
	logic [DATA_WIDTH-1:0]  removed_q;
	logic [DATA_WIDTH-1:0]  last_q;
	logic [DATA_WIDTH-1:0]  rd_q;

	logic                   div_busy;
	logic [CW-1:0]          rem;
	logic [AW-1:0]          last_addr;
	logic [AW-1:0]          rd_addr;
	logic                   rd_en;
	logic                   cnt_zero;
	logic                   cap_le_cnt;

	assign lfsr_nx    = lfsr_next(lfsr_q);
	assign last_addr  = AW'(count_q - 1'b1);
	assign rd_addr    = cmd.rd_slot ? rem[AW-1:0] : last_addr;
	assign rd_en      = cmd.dq_start | cmd.rd_slot;
	assign cnt_zero   = (count_q == '0);
	assign cap_le_cnt = (cap_q <= CAPW'(count_q));

	rq_mod_unit #(
		.CW(CW)
	) u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.dq_start),
		.dividend(lfsr_nx),
		.divisor (count_q),
		.busy    (div_busy),
		.rem     (rem)
	);

	always_comb begin
		stat.is_deq      = (op_q == OP_DEQ);
		stat.enq_refuse  = (count_q >= CW'(DEPTH)) || (fixed_q && cap_le_cnt);
		stat.cnt_zero    = cnt_zero;
		stat.need_grow   = !fixed_q && cap_le_cnt;
		stat.need_shrink = !fixed_q && (XW'({count_q, 2'b00}) < XW'(cap_q));
		stat.div_busy    = div_busy;
		stat.out_free    = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk) begin
		if (cmd.enq_write)
			mem[AW'(count_q)] <= val_q;
		else if (cmd.move)
			mem[rem[AW-1:0]] <= last_q;
		if (rd_en)
			rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			cap_q       <= CAPW'(1);
			fixed_q     <= 1'b0;
			lfsr_q      <= LFSR_W'(1);
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_FIXED:     fixed_q <= cfg_data[0];
					CFG_START_CAP: cap_q   <= CAPW'(cfg_data[START_CAP_W-1:0]);
					CFG_SEED:      lfsr_q  <= (cfg_data == '0) ? LFSR_W'(1) : cfg_data;
					default: ;
				endcase
			end
			if (cmd.grow)
				cap_q <= (cap_q == '0) ? CAPW'(1) : {cap_q[CAPW-2:0], 1'b0};
			if (cmd.shrink)
				cap_q <= cnt_zero ? CAPW'(1) : {1'b0, cap_q[CAPW-1:1]};
			if (cmd.enq_write)
				count_q <= count_q + 1'b1;
			if (cmd.move)
				count_q <= count_q - 1'b1;
			if (cmd.dq_start)
				lfsr_q <= lfsr_nx;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			op_q      <= in_mode;
			val_q     <= DATA_WIDTH'(in_value);
			res_st_q  <= ST_OK;
			removed_q <= '0;
		end
		if (cmd.refuse)
			res_st_q <= (op_q == OP_DEQ) ? ST_EMPTY : ST_FULL;
		if (cmd.grow || cmd.shrink)
			res_st_q <= ST_RESIZED;
		if (cmd.latch_last)
			last_q <= rd_q;
		if (cmd.move)
			removed_q <= rd_q;
		if (cmd.load_out)
			out_data_q <= {{OUT_PAD_W{1'b0}}, CAP_OUT_W'(cap_q), CNT_OUT_W'(count_q),
				ITEM_W'(removed_q), res_st_q};
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above store depth");

	a_enq_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.enq_write |-> count_q < CW'(DEPTH))
		else $error("enqueue write with store full");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_slot |-> (rem < count_q) && !div_busy)
		else $error("slot outside stored entries");

	a_move_dec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.move |=> count_q == CW'($past(count_q) - 1'b1))
		else $error("count not decremented after move");
`endif

endmodule

// ===== dv/randomized_queue_top_tb.sv =====
// Self-checking testbench for randomized_queue_top: enqueue/dequeue traffic on the stream
// ports, register writes between phases, results checked against an in-bench predictor.
// Depends on rq_pkg and the randomized_queue_top RTL.
module randomized_queue_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rq_pkg::*;

	localparam int QUEUE_DEPTH   = DEPTH_DEF;
	localparam int SETTLE_CYCLES = 32;
	localparam int QUIET_LIMIT   = 4000;
	localparam int LOG_LIMIT     = 50;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	typedef struct {
		logic [ST_W-1:0]      status;
		logic [ITEM_W-1:0]    item_out;
		logic [CNT_OUT_W-1:0] entry_count;
		logic [CAP_OUT_W-1:0] capacity_now;
	} queue_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // [31:0] item_value
	logic                   s_axis_tuser = 1'b0; // [0] mode
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;        // [1:0] status, [33:2] item_out,
	                                             // [42:34] entry_count, [52:43] capacity_now
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	// predictor state
	logic [ITEM_W-1:0] q_store [QUEUE_DEPTH];
	int unsigned       q_count = 0;
	int unsigned       q_cap = 1;
	logic [LFSR_W-1:0] q_lfsr = 1;
	logic              q_fixed = 1'b0;

	queue_result_t exp_q[$];

	int send_idle_pct = 0;
	int stall_pct = 0;
	int errors = 0;
	int items_sent = 0;
	int results_checked = 0;
	int status_seen [4] = '{0, 0, 0, 0};
	int quiet_cycles = 0;

	randomized_queue_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic queue_result_t apply_op(input logic op, input logic [ITEM_W-1:0] val);
		queue_result_t r;
		int unsigned   slot;
		r.status = ST_OK;
		r.item_out = '0;
		if (op == OP_ENQ) begin
			if (q_count >= QUEUE_DEPTH) begin
				r.status = ST_FULL;
			end else if (q_fixed && q_cap <= q_count) begin
				r.status = ST_FULL;
			end else begin
				if (!q_fixed) begin
					while (q_cap <= q_count) begin
						q_cap = (q_cap == 0) ? 1 : q_cap * 2;
						r.status = ST_RESIZED;
					end
				end
				q_store[q_count] = val;
				q_count++;
			end
		end else if (q_count == 0) begin
			r.status = ST_EMPTY;
		end else begin
			q_lfsr = {1'b0, q_lfsr[LFSR_W-1:1]} ^ (q_lfsr[0] ? LFSR_TOGGLE : '0);
			slot = q_lfsr % q_count;
			r.item_out = q_store[slot];
			q_store[slot] = q_store[q_count-1];
			q_count--;
			if (!q_fixed) begin
				while (q_count * 4 < q_cap) begin
					r.status = ST_RESIZED;
					if (q_count == 0) begin
						q_cap = 1;
						break;
					end
					q_cap = q_cap / 2;
				end
			end
		end
		r.entry_count = q_count[CNT_OUT_W-1:0];
		r.capacity_now = q_cap[CAP_OUT_W-1:0];
		return r;
	endfunction

	function automatic logic [ITEM_W-1:0] rand_word();
		logic [ITEM_W-1:0] w;
		w = $urandom;
		case ($urandom_range(15))
			0: w = '0;
			1: w = '1;
			default: ;
		endcase
		return w;
	endfunction

	task automatic flag_error(input string what);
		errors++;
		if (errors <= LOG_LIMIT)
			$display("%0t mismatch: %s", $time, what);
	endtask

	task automatic set_idling(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		stall_pct = recv_pct;
	endtask

	// valid stays high after a beat unless a gap follows
	task automatic send_op(input logic op, input logic [ITEM_W-1:0] val);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= val;
		s_axis_tuser <= op;
		do @(posedge clk); while (!s_axis_tready);
		exp_q.push_back(apply_op(op, val));
		items_sent++;
	endtask

	task automatic drain_queue();
		s_axis_tvalid <= 1'b0;
		while (exp_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			CFG_FIXED:     q_fixed = data[0];
			CFG_START_CAP: q_cap = 32'(data[START_CAP_W-1:0]);
			CFG_SEED:      q_lfsr = (data == '0) ? LFSR_W'(1) : data;
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic pick_settings();
		logic [CFG_DATA_W-1:0] d;
		logic [START_CAP_W-1:0] cap;
		drain_queue();
		d = $urandom;
		d[0] = ($urandom_range(2) == 0);
		write_reg(CFG_FIXED, d);
		case ($urandom_range(7))
			0: cap = '0;
			1: cap = 9'd1;
			2: cap = 9'd256;
			3: cap = '1;
			default: cap = START_CAP_W'($urandom_range(2, 64));
		endcase
		d = $urandom;
		d[START_CAP_W-1:0] = cap;
		write_reg(CFG_START_CAP, d);
		d = ($urandom_range(9) == 0) ? '0 : $urandom;
		write_reg(CFG_SEED, d);
		if ($urandom_range(3) == 0)
			write_reg(CFG_UNUSED, $urandom);
	endtask

	task automatic run_mix(input int n_items, input int enq_pct);
		for (int i = 0; i < n_items; i++)
			send_op(($urandom_range(99) < enq_pct) ? OP_ENQ : OP_DEQ, rand_word());
	endtask

	// growing mode from reset values: capacity 1, generator at 1
	task automatic test_reset_state();
		send_op(OP_DEQ, 32'hDEAD_BEEF);
		send_op(OP_ENQ, 32'h0000_0000);
		send_op(OP_ENQ, 32'hFFFF_FFFF);
		send_op(OP_ENQ, 32'hAAAA_AAAA);
		send_op(OP_ENQ, 32'h5555_5555);
		repeat (5) send_op(OP_DEQ, 32'h0);
		// emptying at capacity one still reports a resize
		send_op(OP_ENQ, 32'h0000_0001);
		send_op(OP_DEQ, 32'hFFFF_FFFF);
	endtask

	task automatic test_register_edges();
		drain_queue();
		write_reg(CFG_START_CAP, 32'h0000_0000);
		write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
		send_op(OP_DEQ, 32'h0);
		send_op(OP_ENQ, 32'h8000_0001);
		send_op(OP_DEQ, 32'h0);

		drain_queue();
		write_reg(CFG_SEED, 32'h0000_0000);
		write_reg(CFG_FIXED, 32'hFFFF_FFFF);
		write_reg(CFG_START_CAP, 32'hFFFF_FE00);
		send_op(OP_ENQ, 32'h1234_5678);

		drain_queue();
		write_reg(CFG_START_CAP, 32'h0000_0002);
		write_reg(CFG_SEED, 32'hFFFF_FFFF);
		repeat (3) send_op(OP_ENQ, $urandom);
		repeat (3) send_op(OP_DEQ, $urandom);

		drain_queue();
		write_reg(CFG_FIXED, 32'hFFFF_FFFE);
		write_reg(CFG_START_CAP, 32'h0000_01FF);
		send_op(OP_ENQ, 32'h0000_0007);
		send_op(OP_DEQ, 32'h0);
	endtask

	task automatic test_store_full();
		set_idling(7, 7);
		drain_queue();
		write_reg(CFG_FIXED, 32'h0);
		write_reg(CFG_SEED, $urandom);
		while (q_count < QUEUE_DEPTH)
			send_op(OP_ENQ, rand_word());
		repeat (2) send_op(OP_ENQ, rand_word());
		drain_queue();
		write_reg(CFG_FIXED, 32'h1);
		write_reg(CFG_START_CAP, 32'h1FF);
		send_op(OP_ENQ, rand_word());
		repeat (30) send_op(OP_DEQ, rand_word());
		drain_queue();
		write_reg(CFG_FIXED, 32'h0);
		repeat (10) send_op(OP_DEQ, rand_word());
	endtask

	task automatic test_random_traffic();
		int send_pcts [4] = '{0, 53, 0, 7};
		int recv_pcts [4] = '{0, 0, 53, 7};
		for (int p = 0; p < 4; p++) begin
			set_idling(send_pcts[p], recv_pcts[p]);
			for (int k = 0; k < 3; k++) begin
				pick_settings();
				run_mix(40, $urandom_range(60, 85));
				run_mix(40, $urandom_range(20, 80));
			end
		end
	endtask

	always @(posedge clk)
		m_axis_tready <= ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin : result_check
		queue_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (exp_q.size() == 0) begin
				flag_error($sformatf("result beat %h with nothing expected", m_axis_tdata));
			end else begin
				want = exp_q.pop_front();
				results_checked++;
				status_seen[want.status]++;
				if (m_axis_tdata[ST_W-1:0] !== want.status)
					flag_error($sformatf("status %0d, expected %0d",
						m_axis_tdata[ST_W-1:0], want.status));
				if (m_axis_tdata[ST_W +: ITEM_W] !== want.item_out)
					flag_error($sformatf("item_out %h, expected %h",
						m_axis_tdata[ST_W +: ITEM_W], want.item_out));
				if (m_axis_tdata[ST_W+ITEM_W +: CNT_OUT_W] !== want.entry_count)
					flag_error($sformatf("entry_count %0d, expected %0d",
						m_axis_tdata[ST_W+ITEM_W +: CNT_OUT_W], want.entry_count));
				if (m_axis_tdata[ST_W+ITEM_W+CNT_OUT_W +: CAP_OUT_W] !== want.capacity_now)
					flag_error($sformatf("capacity_now %0d, expected %0d",
						m_axis_tdata[ST_W+ITEM_W+CNT_OUT_W +: CAP_OUT_W],
						want.capacity_now));
				if (m_axis_tdata[OUT_TDATA_W-1:OUT_FIELD_W] !== '0)
					flag_error($sformatf("pad bits %b not zero",
						m_axis_tdata[OUT_TDATA_W-1:OUT_FIELD_W]));
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("no beat for %0d cycles, %0d results outstanding",
				QUIET_LIMIT, exp_q.size());
			$display("[randomized_queue_top] ERROR");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_register_edges();
		test_store_full();
		test_random_traffic();
		drain_queue();
		$display("%0d items sent, %0d results checked: %0d plain, %0d resized, %0d full, %0d empty",
			items_sent, results_checked, status_seen[ST_OK], status_seen[ST_RESIZED],
			status_seen[ST_FULL], status_seen[ST_EMPTY]);
		$display("mismatches counted: %0d", errors);
		if (errors == 0)
			$display("[randomized_queue_top] OK");
		else
			$display("[randomized_queue_top] ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/rq_pkg.sv
hdl/rq_mod_unit.sv
hdl/rq_ctrl.sv
hdl/rq_datapath.sv
hdl/randomized_queue_top.sv
dv/randomized_queue_top_tb.sv
